// File: hdl/mrif_pkg.sv
// Package for the median relative image flagger.
// Holds the sequencer state codes, the register map and the config struct.
// No dependencies.
package mrif_pkg;

    localparam int IDX_W   = 6;
    localparam int CNT_W   = 7;
    localparam int SH_W    = 32;
    localparam int OB_W    = 16;
    localparam int FR_W    = 17;
    localparam int MSH_W   = 33;
    localparam int MOB_W   = 17;
    localparam int SFL_W   = MSH_W + FR_W;
    localparam int OFL_W   = MOB_W + FR_W;
    localparam int PADDR_W = 4;

    localparam logic [1:0] REG_BLUR   = 2'd0;
    localparam logic [1:0] REG_WEAK   = 2'd1;
    localparam logic [1:0] REG_OVER   = 2'd2;

    localparam logic [FR_W-1:0] RST_BLUR = 17'd32768;
    localparam logic [FR_W-1:0] RST_WEAK = 17'd16384;
    localparam logic [FR_W-1:0] RST_OVER = 17'd3277;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_CAND = 3'd1;
    localparam logic [2:0] S_CAP  = 3'd2;
    localparam logic [2:0] S_SCAN = 3'd3;
    localparam logic [2:0] S_DEC  = 3'd4;
    localparam logic [2:0] S_MED  = 3'd5;
    localparam logic [2:0] S_MUL  = 3'd6;
    localparam logic [2:0] S_FLAG = 3'd7;

    typedef struct packed {
        logic [FR_W-1:0] blur;
        logic [FR_W-1:0] wobs;
        logic [FR_W-1:0] over;
    } t_cfg;

endpackage

// File: hdl/median_relative_image_flagger_unit.sv
// Median relative image flagger, top level.
// Depends on mrif_pkg and mrif_cfg.
//
// Frames load one per cycle while busy is low. After the frame with batch_end, busy
// stays high while a single compare unit ranks each stored frame against every stored frame
// (one memory read per cycle), then a median state, a multiply state and a flag pass
// that emits one transaction per cycle with o_valid. The receiver cannot stall;
// results are issued as soon as computed.
module median_relative_image_flagger_unit #(
    parameter int MAX_FRAMES = 64
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [mrif_pkg::PADDR_W-1:0]  paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready,
    input  logic                          start,
    output logic                          busy,
    input  logic [31:0]                   i_sharpness,
    input  logic                          i_is_registered,
    input  logic [15:0]                   i_obs_count,
    input  logic [16:0]                   i_bright_fraction,
    input  logic                          i_batch_end,
    output logic                          o_valid,
    output logic [5:0]                    o_frame_index,
    output logic                          o_is_blurry,
    output logic                          o_is_overexposed,
    output logic                          o_is_weak,
    output logic                          o_is_unregistered,
    output logic [6:0]                    o_blurry_total,
    output logic [6:0]                    o_overexposed_total,
    output logic [6:0]                    o_weak_total,
    output logic [6:0]                    o_unregistered_total,
    output logic [32:0]                   o_median_sharpness,
    output logic [16:0]                   o_median_obs,
    output logic                          o_final_result
);
    localparam logic [mrif_pkg::CNT_W-1:0] MAXN = mrif_pkg::CNT_W'(MAX_FRAMES);

    mrif_pkg::t_cfg w_cfg;

    mrif_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    logic [31:0] mem_sh [0:MAX_FRAMES-1];
    logic        mem_rg [0:MAX_FRAMES-1];
    logic [15:0] mem_ob [0:MAX_FRAMES-1];
    logic [16:0] mem_br [0:MAX_FRAMES-1];

    logic [31:0] r_rd_sh;
    logic        r_rd_rg;
    logic [15:0] r_rd_ob;
    logic [16:0] r_rd_br;

    logic [2:0]  r_state;
    logic [6:0]  r_n, r_ns, r_no, r_j, r_i;
    logic        r_dv;
    logic [5:0]  r_ei;
    logic [31:0] r_c_sh;
    logic        r_c_rg;
    logic [15:0] r_c_ob;
    logic [6:0]  r_lt_s, r_eq_s, r_lt_o, r_eq_o;
    logic [31:0] r_sa, r_sb;
    logic [15:0] r_oa, r_ob;
    logic [32:0] r_med_sh;
    logic [16:0] r_med_ob;
    logic [mrif_pkg::SFL_W-1:0] r_sfl;
    logic [mrif_pkg::OFL_W-1:0] r_ofl;
    logic [6:0]  r_tb, r_to, r_tw, r_tu;

    logic        w_acc, w_store;
    logic [5:0]  w_addr;
    logic [6:0]  w_ka_s, w_kb_s, w_ka_o, w_kb_o;
    logic        w_bl, w_ov, w_wk, w_un;

    assign busy    = (r_state != mrif_pkg::S_IDLE);
    assign w_acc   = start & ~busy;
    assign w_store = w_acc & (r_n < MAXN);
    assign w_ka_s  = (r_ns - 7'd1) >> 1;
    assign w_kb_s  = r_ns >> 1;
    assign w_ka_o  = (r_no - 7'd1) >> 1;
    assign w_kb_o  = r_no >> 1;

    always_comb begin
        case (r_state)
            mrif_pkg::S_CAND: w_addr = r_j[5:0];
            default:          w_addr = r_i[5:0];
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_store) begin
            mem_sh[r_n[5:0]] <= i_sharpness;
            mem_rg[r_n[5:0]] <= i_is_registered;
            mem_ob[r_n[5:0]] <= i_obs_count;
            mem_br[r_n[5:0]] <= i_bright_fraction;
        end
        r_rd_sh <= mem_sh[w_addr];
        r_rd_rg <= mem_rg[w_addr];
        r_rd_ob <= mem_ob[w_addr];
        r_rd_br <= mem_br[w_addr];
    end

    assign w_bl = (r_med_sh != 33'd0) && (r_rd_sh != 32'd0) &&
                  ({1'b0, r_rd_sh, 17'd0} < r_sfl);
    assign w_ov = r_rd_br > w_cfg.over;
    assign w_wk = r_rd_rg && (r_ofl != 34'd0) && ({1'b0, r_rd_ob, 17'd0} < r_ofl);
    assign w_un = ~r_rd_rg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= mrif_pkg::S_IDLE;
            r_n     <= 7'd0;
            r_ns    <= 7'd0;
            r_no    <= 7'd0;
            r_j     <= 7'd0;
            r_i     <= 7'd0;
            r_dv    <= 1'b0;
            r_tb    <= 7'd0;
            r_to    <= 7'd0;
            r_tw    <= 7'd0;
            r_tu    <= 7'd0;
            o_valid <= 1'b0;
        end else begin
            o_valid <= 1'b0;
            r_dv    <= ((r_state == mrif_pkg::S_SCAN) || (r_state == mrif_pkg::S_FLAG))
                       && (r_i < r_n);
            r_ei    <= r_i[5:0];
            case (r_state)
                mrif_pkg::S_IDLE: begin
                    if (w_store) begin
                        r_n <= r_n + 7'd1;
                        if (i_sharpness != 32'd0) r_ns <= r_ns + 7'd1;
                        if (i_is_registered)      r_no <= r_no + 7'd1;
                    end
                    if (w_acc && i_batch_end) begin
                        r_j     <= 7'd0;
                        r_state <= mrif_pkg::S_CAND;
                    end
                end
                mrif_pkg::S_CAND: r_state <= mrif_pkg::S_CAP;
                mrif_pkg::S_CAP: begin
                    r_c_sh  <= r_rd_sh;
                    r_c_rg  <= r_rd_rg;
                    r_c_ob  <= r_rd_ob;
                    r_lt_s  <= 7'd0;
                    r_eq_s  <= 7'd0;
                    r_lt_o  <= 7'd0;
                    r_eq_o  <= 7'd0;
                    r_i     <= 7'd0;
                    r_state <= mrif_pkg::S_SCAN;
                end
                mrif_pkg::S_SCAN: begin
                    if (r_i < r_n) r_i <= r_i + 7'd1;
                    if (r_dv) begin
                        if (r_rd_sh != 32'd0 && r_rd_sh < r_c_sh)  r_lt_s <= r_lt_s + 7'd1;
                        if (r_rd_sh != 32'd0 && r_rd_sh == r_c_sh) r_eq_s <= r_eq_s + 7'd1;
                        if (r_rd_rg && r_rd_ob < r_c_ob)  r_lt_o <= r_lt_o + 7'd1;
                        if (r_rd_rg && r_rd_ob == r_c_ob) r_eq_o <= r_eq_o + 7'd1;
                    end else if (r_i == r_n) begin
                        r_state <= mrif_pkg::S_DEC;
                    end
                end
                mrif_pkg::S_DEC: begin
                    if (r_c_sh != 32'd0) begin
                        if (r_lt_s <= w_ka_s && {1'b0, w_ka_s} < {1'b0, r_lt_s} + {1'b0, r_eq_s})
                            r_sa <= r_c_sh;
                        if (r_lt_s <= w_kb_s && {1'b0, w_kb_s} < {1'b0, r_lt_s} + {1'b0, r_eq_s})
                            r_sb <= r_c_sh;
                    end
                    if (r_c_rg) begin
                        if (r_lt_o <= w_ka_o && {1'b0, w_ka_o} < {1'b0, r_lt_o} + {1'b0, r_eq_o})
                            r_oa <= r_c_ob;
                        if (r_lt_o <= w_kb_o && {1'b0, w_kb_o} < {1'b0, r_lt_o} + {1'b0, r_eq_o})
                            r_ob <= r_c_ob;
                    end
                    r_j <= r_j + 7'd1;
                    if (r_j + 7'd1 == r_n) r_state <= mrif_pkg::S_MED;
                    else                   r_state <= mrif_pkg::S_CAND;
                end
                mrif_pkg::S_MED: begin
                    r_med_sh <= (r_ns == 7'd0) ? 33'd0 : ({1'b0, r_sa} + {1'b0, r_sb});
                    r_med_ob <= (r_no == 7'd0) ? 17'd0 : ({1'b0, r_oa} + {1'b0, r_ob});
                    r_state  <= mrif_pkg::S_MUL;
                end
                mrif_pkg::S_MUL: begin
                    r_sfl   <= r_med_sh * w_cfg.blur;
                    r_ofl   <= r_med_ob * w_cfg.wobs;
                    r_i     <= 7'd0;
                    r_state <= mrif_pkg::S_FLAG;
                end
                mrif_pkg::S_FLAG: begin
                    if (r_i < r_n) r_i <= r_i + 7'd1;
                    if (r_dv) begin
                        o_valid              <= 1'b1;
                        o_frame_index        <= r_ei;
                        o_is_blurry          <= w_bl;
                        o_is_overexposed     <= w_ov;
                        o_is_weak            <= w_wk;
                        o_is_unregistered    <= w_un;
                        o_blurry_total       <= r_tb + {6'd0, w_bl};
                        o_overexposed_total  <= r_to + {6'd0, w_ov};
                        o_weak_total         <= r_tw + {6'd0, w_wk};
                        o_unregistered_total <= r_tu + {6'd0, w_un};
                        o_median_sharpness   <= r_med_sh;
                        o_median_obs         <= r_med_ob;
                        o_final_result       <= ({1'b0, r_ei} + 7'd1 == r_n);
                        r_tb <= r_tb + {6'd0, w_bl};
                        r_to <= r_to + {6'd0, w_ov};
                        r_tw <= r_tw + {6'd0, w_wk};
                        r_tu <= r_tu + {6'd0, w_un};
                    end else if (r_i == r_n) begin
                        r_n     <= 7'd0;
                        r_ns    <= 7'd0;
                        r_no    <= 7'd0;
                        r_tb    <= 7'd0;
                        r_to    <= 7'd0;
                        r_tw    <= 7'd0;
                        r_tu    <= 7'd0;
                        r_state <= mrif_pkg::S_IDLE;
                    end
                end
                default: r_state <= mrif_pkg::S_IDLE;
            endcase
        end
    end

endmodule

// File: hdl/mrif_cfg.sv
// Configuration register file on an APB-style port.
// Depends on mrif_pkg.
module mrif_cfg (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [mrif_pkg::PADDR_W-1:0]  paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready,
    output mrif_pkg::t_cfg                o_cfg
);
    mrif_pkg::t_cfg r_cfg;
    logic           w_wr;

    assign pready = 1'b1;
    assign w_wr   = psel & penable & pwrite;
    assign o_cfg  = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.blur <= mrif_pkg::RST_BLUR;
            r_cfg.wobs <= mrif_pkg::RST_WEAK;
            r_cfg.over <= mrif_pkg::RST_OVER;
        end else if (w_wr) begin
            case (paddr[3:2])
                mrif_pkg::REG_BLUR: r_cfg.blur <= pwdata[mrif_pkg::FR_W-1:0];
                mrif_pkg::REG_WEAK: r_cfg.wobs <= pwdata[mrif_pkg::FR_W-1:0];
                mrif_pkg::REG_OVER: r_cfg.over <= pwdata[mrif_pkg::FR_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[3:2])
            mrif_pkg::REG_BLUR: prdata = {15'd0, r_cfg.blur};
            mrif_pkg::REG_WEAK: prdata = {15'd0, r_cfg.wobs};
            mrif_pkg::REG_OVER: prdata = {15'd0, r_cfg.over};
            default:            prdata = 32'd0;
        endcase
    end

endmodule
